// ===== design/u2h_pkg.sv =====
// ----------------------------------------------------------------------------
// u2h_pkg: shared definitions for the UTF-8 to HTML reference converter
// Character codes, error codes and code point widths used by the converter
// and its port checker.
// ----------------------------------------------------------------------------
package u2h_pkg;

   localparam int CodeWidth = 32;            // width of a gathered code point
   localparam int NumDigits = 10;            // decimal digits of a 32-bit value

   localparam logic [1:0] ErrNone  = 2'd0;
   localparam logic [1:0] ErrLead  = 2'd1;   // invalid lead byte
   localparam logic [1:0] ErrTrunc = 2'd2;   // sequence cut off at string end

   localparam logic [7:0] CharAmp  = 8'h26;
   localparam logic [7:0] CharHash = 8'h23;
   localparam logic [7:0] CharSemi = 8'h3B;
   localparam logic [7:0] CharZero = 8'h30;

endpackage

// ===== design/utf8_to_html_numeric_escape.sv =====
// ----------------------------------------------------------------------------
// utf8_to_html_numeric_escape: UTF-8 byte stream to "&#N;" converter
// Passes ASCII bytes through, gathers multi-byte sequences into a code point
// and writes the code point out as a decimal character reference.
// ----------------------------------------------------------------------------
// A byte that completes no sequence is taken, and any single result it
// causes sits in the output register from the next cycle. A byte that
// completes a sequence is taken, then passes through the shift-and-add-three
// unit that turns the 32-bit code point into ten BCD digits, one bit per
// cycle, and its characters (4 to 13 of them) are then loaded into the output
// register in order as it frees. The block accepts no new byte until the
// last character of a reference has been loaded into the output register.
module utf8_to_html_numeric_escape (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_done,
   output logic [1:0] rsp_error_code
);

   localparam int CW = u2h_pkg::CodeWidth;
   localparam int ND = u2h_pkg::NumDigits;
   localparam int CntW = $clog2(CW);
   localparam int DigW = $clog2(ND);

   typedef enum logic [2:0] {
      S_IDLE, S_CONV, S_AMP, S_HASH, S_DIG, S_SEMI
   } state_type;

   state_type                  state_ff, state_in;
   logic [CW-1:0]              accum_ff, accum_in;
   logic [2:0]                 pending_ff, pending_in;
   logic                       discard_ff, discard_in;
   logic                       eos_ff, eos_in;
   logic [CW-1:0]              shift_ff, shift_in;
   logic [ND-1:0][3:0]         bcd_ff, bcd_in;
   logic [ND-1:0][3:0]         bcd_adj;
   logic [CntW-1:0]            count_ff, count_in;
   logic [DigW-1:0]            dig_ff, dig_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 out_byte_ff, out_byte_in;
   logic                       run_last_ff, run_last_in;
   logic                       done_ff, done_in;
   logic [1:0]                 err_ff, err_in;
   logic                       can_load;
   logic [CW-1:0]              acc_next;
   logic [2:0]                 pend_next;

   function automatic logic [DigW-1:0] lead_digit(input logic [ND-1:0][3:0] d);
      logic [DigW-1:0] idx;
      idx = '0;
      for (int i = 0; i < ND; i++) begin
         if (d[i] != 4'd0) idx = DigW'(i);
      end
      return idx;
   endfunction

   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && can_load;

   assign acc_next  = {accum_ff[CW-7:0], 6'b0} + {{(CW-8){1'b0}}, req_in_byte} - CW'(128);
   assign pend_next = pending_ff - 3'd1;

   always_comb begin
      for (int i = 0; i < ND; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      accum_in     = accum_ff;
      pending_in   = pending_ff;
      discard_in   = discard_ff;
      eos_in       = eos_ff;
      shift_in     = shift_ff;
      bcd_in       = bcd_ff;
      count_in     = count_ff;
      dig_in       = dig_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      run_last_in  = run_last_ff;
      done_in      = done_ff;
      err_in       = err_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (discard_ff) begin
                  if (req_end_of_string) discard_in = 1'b0;
               end else if (pending_ff != 3'd0) begin
                  if (pend_next == 3'd0) begin
                     shift_in   = acc_next;
                     bcd_in     = '0;
                     count_in   = '0;
                     eos_in     = req_end_of_string;
                     accum_in   = '0;
                     pending_in = 3'd0;
                     state_in   = S_CONV;
                  end else if (req_end_of_string) begin
                     accum_in     = '0;
                     pending_in   = 3'd0;
                     rsp_valid_in = 1'b1;
                     out_byte_in  = 8'd0;
                     run_last_in  = 1'b1;
                     done_in      = 1'b1;
                     err_in       = u2h_pkg::ErrTrunc;
                  end else begin
                     accum_in   = acc_next;
                     pending_in = pend_next;
                  end
               end else if (!req_in_byte[7]) begin
                  rsp_valid_in = 1'b1;
                  out_byte_in  = req_in_byte;
                  run_last_in  = 1'b1;
                  done_in      = req_end_of_string;
                  err_in       = u2h_pkg::ErrNone;
               end else if (req_in_byte[7:6] == 2'b10 || req_in_byte[7:1] == 7'h7F) begin
                  // A stray continuation byte or 254/255 kills the rest of the string.
                  discard_in   = !req_end_of_string;
                  rsp_valid_in = 1'b1;
                  out_byte_in  = 8'd0;
                  run_last_in  = 1'b1;
                  done_in      = 1'b1;
                  err_in       = u2h_pkg::ErrLead;
               end else if (req_end_of_string) begin
                  rsp_valid_in = 1'b1;
                  out_byte_in  = 8'd0;
                  run_last_in  = 1'b1;
                  done_in      = 1'b1;
                  err_in       = u2h_pkg::ErrTrunc;
               end else begin
                  // The first zero below the leading ones sets the sequence length.
                  if (!req_in_byte[5]) begin
                     pending_in = 3'd1;
                     accum_in   = {{(CW-5){1'b0}}, req_in_byte[4:0]};
                  end else if (!req_in_byte[4]) begin
                     pending_in = 3'd2;
                     accum_in   = {{(CW-4){1'b0}}, req_in_byte[3:0]};
                  end else if (!req_in_byte[3]) begin
                     pending_in = 3'd3;
                     accum_in   = {{(CW-3){1'b0}}, req_in_byte[2:0]};
                  end else if (!req_in_byte[2]) begin
                     pending_in = 3'd4;
                     accum_in   = {{(CW-2){1'b0}}, req_in_byte[1:0]};
                  end else begin
                     pending_in = 3'd5;
                     accum_in   = {{(CW-1){1'b0}}, req_in_byte[0]};
                  end
               end
            end
         end
         S_CONV: begin
            // One binary bit moves into the BCD register per cycle.
            bcd_in   = {bcd_adj[ND-1:0]} << 1;
            bcd_in[0][0] = shift_ff[CW-1];
            shift_in = shift_ff << 1;
            count_in = count_ff + CntW'(1);
            if (count_ff == CntW'(CW-1)) state_in = S_AMP;
         end
         S_AMP: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               out_byte_in  = u2h_pkg::CharAmp;
               run_last_in  = 1'b0;
               done_in      = 1'b0;
               err_in       = u2h_pkg::ErrNone;
               state_in     = S_HASH;
            end
         end
         S_HASH: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               out_byte_in  = u2h_pkg::CharHash;
               run_last_in  = 1'b0;
               done_in      = 1'b0;
               err_in       = u2h_pkg::ErrNone;
               dig_in       = lead_digit(bcd_ff);
               state_in     = S_DIG;
            end
         end
         S_DIG: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               out_byte_in  = u2h_pkg::CharZero + {4'd0, bcd_ff[dig_ff]};
               run_last_in  = 1'b0;
               done_in      = 1'b0;
               err_in       = u2h_pkg::ErrNone;
               if (dig_ff == '0) state_in = S_SEMI;
               else dig_in = dig_ff - DigW'(1);
            end
         end
         S_SEMI: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               out_byte_in  = u2h_pkg::CharSemi;
               run_last_in  = 1'b1;
               done_in      = eos_ff;
               err_in       = u2h_pkg::ErrNone;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         accum_ff     <= '0;
         pending_ff   <= 3'd0;
         discard_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         accum_ff     <= accum_in;
         pending_ff   <= pending_in;
         discard_ff   <= discard_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      eos_ff      <= eos_in;
      shift_ff    <= shift_in;
      bcd_ff      <= bcd_in;
      count_ff    <= count_in;
      dig_ff      <= dig_in;
      out_byte_ff <= out_byte_in;
      run_last_ff <= run_last_in;
      done_ff     <= done_in;
      err_ff      <= err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_string_done = done_ff;
   assign rsp_error_code  = err_ff;

endmodule

// ===== design/u2h_checker.sv =====
// ----------------------------------------------------------------------------
// u2h_checker: port checks for the UTF-8 to HTML reference converter
// Watches the result channel for protocol and result-format slips.
// ----------------------------------------------------------------------------
module u2h_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_string_done,
   input logic [1:0] rsp_error_code
);

   // A stalled result must hold until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_error_code) && $stable(rsp_string_done))
      else $error("result changed while stalled");

   // Error results carry a zero character and close the string.
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != u2h_pkg::ErrNone |->
         rsp_out_byte == 8'd0 && rsp_run_last && rsp_string_done)
      else $error("malformed error result");

   // The end of a string is always the end of its byte's run.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_done |-> rsp_run_last)
      else $error("string end without run end");

   // Only the three defined error codes appear.
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code == u2h_pkg::ErrNone
         || rsp_error_code == u2h_pkg::ErrLead || rsp_error_code == u2h_pkg::ErrTrunc)
      else $error("undefined error code");

   // No byte is taken while a result is stuck in the output register.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid || rsp_ready)
      else $error("input ready while output stalled");

endmodule

bind utf8_to_html_numeric_escape u2h_checker u_u2h_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_run_last      (rsp_run_last),
   .rsp_string_done   (rsp_string_done),
   .rsp_error_code    (rsp_error_code)
);
